### sv/seven_segment_text_encoder_unit_macros.svh
// Assertion macros shared by the encoder modules.
// Each macro takes a label, the clock, the reset, an antecedent, a consequent and a message.
`ifndef SEVEN_SEGMENT_TEXT_ENCODER_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_TEXT_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SSTE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SSTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSTE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SSTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### sv/sste_pkg.sv
`timescale 1ns / 1ps
package sste_pkg;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] MAX_DIGITS = 5'd16;
  localparam logic [CNT_W-1:0] DIGIT_COUNT_RESET = 5'd5;

  localparam int TABLE_SIZE = 47;
  localparam logic [5:0] BLANK_IDX = 6'd36;
  localparam logic [5:0] SYM_BASE_IDX = 6'd37;
  localparam logic [5:0] LETTER_BASE_IDX = 6'd10;

  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] DOT_MASK = 8'h01;
  localparam logic [7:0] STROBE_SEG = 8'h00;

  localparam logic [7:0] SEG_TABLE [TABLE_SIZE] = '{
    8'h7E, 8'h12, 8'hBC, 8'hB6, 8'hD2, 8'hE6, 8'hEE, 8'h32, 8'hFE, 8'hF6,
    8'hFA, 8'hCE, 8'h6C, 8'h9E, 8'hEC, 8'hE8, 8'h6E, 8'hDA, 8'h48, 8'h1E,
    8'hEA, 8'h4C, 8'h7A, 8'h8A, 8'h8E, 8'hF8, 8'hF2, 8'h88, 8'hE6, 8'hCC,
    8'h0E, 8'h5E, 8'hDE, 8'hDA, 8'hD2, 8'hBC,
    8'h00,
    8'hC8, 8'h5A, 8'hF0,
    8'h80, 8'h20, 8'h10, 8'h02, 8'h04, 8'h08, 8'h40
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAR,
    S_PAD,
    S_STROBE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_item;
    logic emit_char;
    logic set_dot;
    logic emit_pad;
    logic emit_strobe;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_char;
    logic is_dot;
    logic is_last;
    logic below_lim;
    logic slot_free;
  } stat_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] pattern;
  } lookup_t;

  function automatic lookup_t seg_lookup(input logic [7:0] code);
    logic [5:0] idx;
    logic       hit;
    lookup_t    r;
    hit = 1'b1;
    idx = '0;
    priority if (code >= 8'h30 && code <= 8'h39) begin
      idx = 6'(code - 8'h30);
    end else if (code >= 8'h61 && code <= 8'h7A) begin
      idx = 6'(code - 8'h61) + LETTER_BASE_IDX;
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      idx = 6'(code - 8'h41) + LETTER_BASE_IDX;
    end else if (code == 8'h20 || (code >= 8'h09 && code <= 8'h0D)) begin
      idx = BLANK_IDX;
    end else if (code >= 8'h80 && code <= 8'h89) begin
      idx = SYM_BASE_IDX + 6'(code - 8'h80);
    end else begin
      hit = 1'b0;
    end
    r.hit = hit;
    r.pattern = SEG_TABLE[idx];
    return r;
  endfunction

endpackage

### sv/seven_segment_text_encoder_unit.sv
`timescale 1ns / 1ps
// Seven-segment text encoder. Characters enter on the input channel
// (in_valid/in_ready, fields char_code, char_valid, end_of_text), last
// character of the text first. Each displayable character leaves as one
// segment byte beat on the output channel (out_valid/out_ready, fields
// segments, strobe_res); a dot or colon marks the next byte with bit 0.
// The final item of a text pads with blank bytes up to the digit count and
// then gives one strobe beat with segments zero.
// The digit count is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, as the block does not enforce this.
// Values above sixteen act as sixteen. An item is taken in one cycle and
// evaluated in the next, and the block takes no new item until it is
// through with the last one. A mapped character passes the item register
// and then the output register on its way out. The final item then sends
// each padding byte, leaves padding and sends the strobe, each byte going
// through the single output register.
// When the receiver stalls, the output register holds its beat and the
// controller waits before loading another byte; items can still be taken
// until one needs a byte loaded. Reset clears the digit counter, the
// pending dot and the output valid flag, and sets the digit count to five.
module seven_segment_text_encoder_unit import sste_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       char_code,
  input  logic             char_valid,
  input  logic             end_of_text,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       segments,
  output logic             strobe_res
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences each item: take it, evaluate it, then pad and
  // strobe on the final item.
  sste_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the item, the counters, the lookup and the output
  // register.
  sste_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .char_code   (char_code),
    .char_valid  (char_valid),
    .end_of_text (end_of_text),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .segments    (segments),
    .strobe_res  (strobe_res)
  );

endmodule

### sv/sste_ctrl.sv
`timescale 1ns / 1ps
`include "seven_segment_text_encoder_unit_macros.svh"
module sste_ctrl import sste_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHAR;
      end
      S_CHAR: begin
        if (!stat.has_char || stat.slot_free) begin
          state_next = stat.is_last ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        if (!stat.below_lim) state_next = S_STROBE;
      end
      S_STROBE: begin
        if (stat.slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.latch_item = in_valid;
      end
      S_CHAR: begin
        cmd.emit_char = stat.has_char && stat.slot_free;
        cmd.set_dot = stat.is_dot;
      end
      S_PAD: begin
        cmd.emit_pad = stat.below_lim && stat.slot_free;
      end
      S_STROBE: begin
        cmd.emit_strobe = stat.slot_free;
      end
      default: cmd = '0;
    endcase
  end

  `SSTE_ASSERT_IMPLY(a_one_cmd, clk, rst, 1'b1, $onehot0(cmd), "more than one command")
  `SSTE_ASSERT_NEXT(a_latch_to_char, clk, rst, cmd.latch_item, state == S_CHAR,
    "latched item not evaluated")
  `SSTE_ASSERT_IMPLY(a_ready_idle, clk, rst, in_ready, state == S_IDLE, "ready outside idle")

endmodule

### sv/sste_dp.sv
`timescale 1ns / 1ps
`include "seven_segment_text_encoder_unit_macros.svh"
module sste_dp import sste_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic [7:0]       char_code,
  input  logic             char_valid,
  input  logic             end_of_text,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       segments,
  output logic             strobe_res
);

  logic [CNT_W-1:0] digit_count;
  logic [CNT_W-1:0] digits_sent;
  logic             dot_pending;
  logic [7:0]       item_code;
  logic             item_valid;
  logic             item_last;
  logic             out_full;
  logic [CNT_W-1:0] lim;
  lookup_t          look;
  logic             load;
  logic             is_sep;

  assign lim = (digit_count > MAX_DIGITS) ? MAX_DIGITS : digit_count;
  assign look = seg_lookup(item_code);
  assign is_sep = (item_code == CHAR_DOT) || (item_code == CHAR_COLON);
  assign load = cmd.emit_char || cmd.emit_pad || cmd.emit_strobe;

  assign stat.below_lim = digits_sent < lim;
  assign stat.has_char = item_valid && stat.below_lim && !is_sep && look.hit;
  assign stat.is_dot = item_valid && stat.below_lim && is_sep;
  assign stat.is_last = item_last;
  // The output register can take a new beat when empty or draining this cycle.
  assign stat.slot_free = !out_full || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= DIGIT_COUNT_RESET;
      digits_sent <= '0;
      dot_pending <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (cfg_we) digit_count <= cfg_wdata;
      if (load) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
      if (cmd.emit_char || cmd.emit_pad) digits_sent <= digits_sent + 5'd1;
      if (cmd.emit_strobe) digits_sent <= '0;
      if (cmd.set_dot) dot_pending <= 1'b1;
      if (cmd.emit_char || cmd.emit_strobe) dot_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_code <= char_code;
      item_valid <= char_valid;
      item_last <= end_of_text;
    end
    if (cmd.emit_char) begin
      segments <= dot_pending ? (look.pattern | DOT_MASK) : look.pattern;
      strobe_res <= 1'b0;
    end else if (cmd.emit_pad) begin
      segments <= SEG_TABLE[BLANK_IDX];
      strobe_res <= 1'b0;
    end else if (cmd.emit_strobe) begin
      segments <= STROBE_SEG;
      strobe_res <= 1'b1;
    end
  end

  assign out_valid = out_full;

  `SSTE_ASSERT_IMPLY(a_no_overwrite, clk, rst, load, !out_full || out_ready,
    "output overwritten while stalled")
  `SSTE_ASSERT_NEXT(a_strobe_clears, clk, rst, cmd.emit_strobe,
    digits_sent == '0 && !dot_pending, "state not cleared after strobe")
  `SSTE_ASSERT_IMPLY(a_sent_bound, clk, rst, 1'b1, digits_sent <= MAX_DIGITS,
    "digit counter out of range")

endmodule

### dv/tb_seven_segment_text_encoder_unit.sv
`timescale 1ns / 1ps
// Block-level testbench for the seven-segment text encoder.
//
// The sender feeds characters of a text, last character first, over the
// in_valid/in_ready channel. The receiver takes segment bytes and strobes
// over the out_valid/out_ready channel. A small scoreboard carries its own
// copy of the digit count, the digit counter and the pending-dot flag. It
// turns every accepted input beat into the output beats it must cause, and it
// checks each output beat against the oldest of those in order.
module tb_seven_segment_text_encoder_unit;
  import sste_pkg::*;

  // Glyph table positions for the groups of characters that the display knows.
  localparam int GLYPH_LETTER = 10;
  localparam int GLYPH_BLANK = 36;
  localparam int GLYPH_SYMBOL = 37;
  localparam logic [7:0] SYMBOL_FIRST = 8'h80;
  localparam logic [7:0] SYMBOL_LAST = 8'h89;
  localparam logic [7:0] SYMBOL_NONE = 8'h8A;

  // Segment patterns, in the order digits, letters, blank, then symbols.
  localparam logic [7:0] GLYPHS [47] = '{
    8'h7E, 8'h12, 8'hBC, 8'hB6, 8'hD2, 8'hE6, 8'hEE, 8'h32, 8'hFE, 8'hF6,
    8'hFA, 8'hCE, 8'h6C, 8'h9E, 8'hEC, 8'hE8, 8'h6E, 8'hDA, 8'h48, 8'h1E,
    8'hEA, 8'h4C, 8'h7A, 8'h8A, 8'h8E, 8'hF8, 8'hF2, 8'h88, 8'hE6, 8'hCC,
    8'h0E, 8'h5E, 8'hDE, 8'hDA, 8'hD2, 8'hBC,
    8'h00,
    8'hC8, 8'h5A, 8'hF0,
    8'h80, 8'h20, 8'h10, 8'h02, 8'h04, 8'h08, 8'h40
  };

  localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES = 12;  // covers an item still in flight
  localparam int ITEM_TARGET = 350;
  localparam int CALM_ITEMS = 60;     // the tail of the run has no idling
  localparam int ERROR_PRINTS = 200;

  typedef struct packed {
    logic [7:0] segments;
    logic       strobe;
  } seg_beat_t;

  // Holds the encoder state as the block should see it and the queue of
  // output beats that are still owed.
  class segment_scoreboard;
    logic [CNT_W-1:0] digit_count;
    logic [CNT_W-1:0] digits_sent;
    logic             dot_pending;
    seg_beat_t        expected_beats[$];
    int               errors;

    function new();
      digit_count = DIGIT_COUNT_RESET;
      digits_sent = '0;
      dot_pending = 1'b0;
      errors = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      digit_count = value;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Position in the glyph table, or -1 for a code the display skips.
    function int glyph_index(logic [7:0] code);
      if (code >= 8'h30 && code <= 8'h39) return int'(code - 8'h30);
      if (code >= 8'h61 && code <= 8'h7A) return int'(code - 8'h61) + GLYPH_LETTER;
      if (code >= 8'h41 && code <= 8'h5A) return int'(code - 8'h41) + GLYPH_LETTER;
      if (code == 8'h20 || (code >= 8'h09 && code <= 8'h0D)) return GLYPH_BLANK;
      if (code >= SYMBOL_FIRST && code <= SYMBOL_LAST) begin
        return GLYPH_SYMBOL + int'(code - SYMBOL_FIRST);
      end
      return -1;
    endfunction

    // Works out the output beats of one accepted input beat.
    function void encode_item(logic [7:0] code, logic valid_char, logic last);
      logic [CNT_W-1:0] limit;
      int               idx;
      limit = (digit_count > MAX_DIGITS) ? MAX_DIGITS : digit_count;
      if (valid_char && digits_sent < limit) begin
        if (code == CHAR_DOT || code == CHAR_COLON) begin
          dot_pending = 1'b1;
        end else begin
          idx = glyph_index(code);
          if (idx >= 0) begin
            expected_beats.push_back('{GLYPHS[idx] | (dot_pending ? DOT_MASK : 8'h00),
                                       1'b0});
            dot_pending = 1'b0;
            digits_sent = digits_sent + 1'b1;
          end
        end
      end
      if (last) begin
        while (digits_sent < limit) begin
          expected_beats.push_back('{GLYPHS[GLYPH_BLANK], 1'b0});
          digits_sent = digits_sent + 1'b1;
        end
        expected_beats.push_back('{STROBE_SEG, 1'b1});
        digits_sent = '0;
        dot_pending = 1'b0;
      end
    endfunction

    function void check_beat(logic [7:0] segments, logic strobe_res);
      seg_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= ERROR_PRINTS) begin
          $error("beat with nothing expected: segments=%h strobe_res=%b",
                 segments, strobe_res);
        end
        return;
      end
      want = expected_beats.pop_front();
      if (segments !== want.segments) begin
        errors++;
        if (errors <= ERROR_PRINTS) begin
          $error("segments: expected %h, actual %h", want.segments, segments);
        end
      end
      if (strobe_res !== want.strobe) begin
        errors++;
        if (errors <= ERROR_PRINTS) begin
          $error("strobe_res: expected %b, actual %b", want.strobe, strobe_res);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       char_code = '0;
  logic             char_valid = 1'b0;
  logic             end_of_text = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       segments;
  logic             strobe_res;

  segment_scoreboard board = new();
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;

  seven_segment_text_encoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .char_valid (char_valid),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .segments   (segments),
    .strobe_res (strobe_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Both channels are sampled at the rising edge, before any of this edge's
  // nonblocking updates land. An input beat is noted before the output beat of
  // the same edge is checked; the block cannot answer a beat in its own cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.encode_item(char_code, char_valid, end_of_text);
      if (out_valid && out_ready) board.check_beat(segments, strobe_res);
    end
  end

  // The receiver drops ready for bursts of random length while stalls are on.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // A hung block shows up as a long stretch with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Presents one input beat and returns at the edge that takes it. Valid stays
  // high into the next call unless a gap is drawn there.
  task automatic send_item(input logic [7:0] code, input logic valid_char,
                           input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= code;
    char_valid <= valid_char;
    end_of_text <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Holds the sender back until every owed beat has come out, then lets an
  // item that gives no beat finish its way through the block.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_digit_count(input logic [CNT_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_count(value);
  endtask

  // Mostly displayable characters, with dots, colons and stray codes mixed in.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 45) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 55) return 8'h41 + 8'($urandom_range(0, 25));
    if (r < 58) return 8'h20;
    if (r < 62) return 8'h09 + 8'($urandom_range(0, 4));
    if (r < 72) return SYMBOL_FIRST + 8'($urandom_range(0, 9));
    if (r < 78) return CHAR_DOT;
    if (r < 84) return CHAR_COLON;
    return 8'($urandom_range(0, 255));
  endfunction

  // Small counts dominate; zero, one, sixteen and the saturating values
  // come up regularly.
  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2: return MAX_DIGITS;
      3: return 5'd31;
      4: return 5'($urandom_range(17, 30));
      default: return 5'($urandom_range(1, 8));
    endcase
  endfunction

  // One text: its characters, a few invalid beats among them, and a final
  // beat that is sometimes an empty flush. Now and then the digit count is
  // rewritten halfway through, once the block has gone quiet.
  task automatic send_text(input int length);
    int k;
    for (k = 0; k < length - 1; k++) begin
      if (k == length / 2 && $urandom_range(0, 14) == 0) set_digit_count(pick_count());
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      else send_item(pick_char(), 1'b1, 1'b0);
    end
    if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    else send_item(pick_char(), 1'b1, 1'b1);
  endtask

  initial begin
    int phase_texts;
    int t;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    stalls_on = 1'b1;

    // Reset count of five. A dot survives a skipped code and lands on the
    // next byte, invalid beats change nothing, and once five bytes are out
    // the rest of the text, dots and the final character included, is dropped.
    send_item(8'h39, 1'b1, 1'b0);
    send_item(CHAR_DOT, 1'b1, 1'b0);
    send_item(SYMBOL_NONE, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(CHAR_COLON, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(SYMBOL_LAST, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h0D, 1'b1, 1'b0);
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'h7A, 1'b1, 1'b0);
    send_item(CHAR_DOT, 1'b1, 1'b0);
    send_item(8'h30, 1'b1, 1'b1);

    // A dot still pending when the text ends is dropped, not put on padding.
    send_item(8'h41, 1'b1, 1'b0);
    send_item(CHAR_COLON, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // With no digits only the strobe comes out.
    set_digit_count(5'd0);
    send_item(8'h35, 1'b1, 1'b0);
    send_item(8'h09, 1'b1, 1'b1);

    // The largest count saturates at sixteen; an empty flush then gives the
    // longest burst of beats that one item can cause.
    set_digit_count(5'd31);
    send_item(SYMBOL_FIRST, 1'b1, 1'b0);
    send_item(8'h20, 1'b1, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);

    // Lowering the count below what a text has already shown stops it there
    // with no padding.
    set_digit_count(5'd8);
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'h32, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b0);
    set_digit_count(5'd2);
    send_item(8'h34, 1'b1, 1'b1);

    // Random phases: a new count, then a handful of texts. Idling on each side
    // is switched per phase and stays off for the tail of the run.
    while (items_sent < ITEM_TARGET) begin
      gaps_on = (items_sent < ITEM_TARGET - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      stalls_on = (items_sent < ITEM_TARGET - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      set_digit_count(pick_count());
      phase_texts = $urandom_range(2, 6);
      for (t = 0; t < phase_texts && items_sent < ITEM_TARGET; t++) begin
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
          gaps_on = 1'b0;
          stalls_on = 1'b0;
        end
        if ($urandom_range(0, 9) == 0) send_text($urandom_range(15, 24));
        else send_text($urandom_range(1, 12));
      end
    end

    drain();
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
